// ===== hw/rtl/linear_to_mixed_radix_digits_top_defines.svh =====
// ----------------------------------------------------------------------------
// Mixed-radix digit splitter: assertion macros
// Shared assertion forms for the checker. Clock is clk, reset is rst_n.
// ----------------------------------------------------------------------------
`ifndef LINEAR_TO_MIXED_RADIX_DIGITS_TOP_DEFINES_SVH
`define LINEAR_TO_MIXED_RADIX_DIGITS_TOP_DEFINES_SVH

// same-cycle implication
`define LMRD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lmrd: same-cycle check failed");

// next-cycle implication
`define LMRD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lmrd: next-cycle check failed");

`endif

// ===== hw/rtl/lmrd_pkg.sv =====
// ----------------------------------------------------------------------------
// lmrd_pkg
// Constants and types shared by the mixed-radix digit splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package lmrd_pkg;

    localparam int MAX_DIGITS_DEF = 4;

    localparam int INDEX_W  = 32;
    localparam int RADIX_W  = 16;
    localparam int WEIGHT_W = 48;
    localparam int COUNT_W  = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int POS_W    = 2;
    localparam int NUM_RADIX = 4;

    localparam logic [CFG_IDX_W-1:0] REG_DIGIT_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RADIX_0     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIX_1     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RADIX_2     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RADIX_3     = 3'd4;

    typedef struct packed {
        logic                start;
        logic [INDEX_W-1:0]  dividend;
        logic [WEIGHT_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [INDEX_W-1:0] quotient;
        logic [INDEX_W-1:0] remainder;
    } div_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/linear_to_mixed_radix_digits_top.sv =====
// ----------------------------------------------------------------------------
// linear_to_mixed_radix_digits_top
// Splits a 32-bit linear index into mixed-radix digits, most significant
// first, one result per digit, with an out-of-range flag on every result.
//
// Channel   Handshake               Payload
// input     start & !busy           joint_index
// result    valid (one cycle)       position, digit, last, out_of_range
// config    cfg_we                  cfg_index, cfg_data
//
// Busy drops with the last result of an item. Each digit is worked out on
// the shared 32-step restoring divider; place weights and the range product
// come first from one 16x32 multiplier.
// Reset: all radices 1, one digit in use, no item in flight.
// Results cannot be stalled; each is shown for one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_to_mixed_radix_digits_top #(
    parameter int MAX_DIGITS = lmrd_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [lmrd_pkg::INDEX_W-1:0]    joint_index,
    output logic                                 valid,
    output logic [lmrd_pkg::POS_W-1:0]           position,
    output logic [lmrd_pkg::INDEX_W-1:0]         digit,
    output logic                                 last,
    output logic                                 out_of_range,
    input  wire logic                            cfg_we,
    input  wire logic [lmrd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lmrd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import lmrd_pkg::*;

    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int MUL_W = RADIX_W + INDEX_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WGT  = 3'd1;
    localparam logic [2:0] S_PLO  = 3'd2;
    localparam logic [2:0] S_PHI  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;

    logic [COUNT_W-1:0] digit_count_reg;
    logic [RADIX_W-1:0] radix_reg [NUM_RADIX];

    logic [2:0]          state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [IDX_W-1:0]    last_idx_reg, last_idx_next;
    logic [INDEX_W-1:0]  rem_reg, rem_next;
    logic [MUL_W-1:0]    plo_reg, plo_next;
    logic                oor_reg, oor_next;
    logic                div_start_reg, div_start_next;
    logic                valid_reg, valid_next;
    logic [POS_W-1:0]    position_reg, position_next;
    logic [INDEX_W-1:0]  digit_reg, digit_next;
    logic                last_reg, last_next;
    logic [WEIGHT_W-1:0] weight_reg [MAX_DIGITS];

    logic                weight_we;
    logic [IDX_W-1:0]    weight_waddr;
    logic [WEIGHT_W-1:0] weight_wdata;

    logic [COUNT_W-1:0]  count_lim;
    logic [IDX_W-1:0]    last_idx_calc;
    logic [WEIGHT_W-1:0] weight_rd;
    logic [RADIX_W-1:0]  mul_a;
    logic [INDEX_W-1:0]  mul_b;
    logic [MUL_W-1:0]    mul_out;

    div_req_t div_req;
    div_rsp_t div_rsp;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_count_reg <= COUNT_W'(1);
            for (int i = 0; i < NUM_RADIX; i++)
            begin
                radix_reg[i] <= RADIX_W'(1);
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DIGIT_COUNT: digit_count_reg <= cfg_data[COUNT_W-1:0];
                REG_RADIX_0:     radix_reg[0]    <= cfg_data[RADIX_W-1:0];
                REG_RADIX_1:     radix_reg[1]    <= cfg_data[RADIX_W-1:0];
                REG_RADIX_2:     radix_reg[2]    <= cfg_data[RADIX_W-1:0];
                REG_RADIX_3:     radix_reg[3]    <= cfg_data[RADIX_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        if (digit_count_reg == '0)
            count_lim = COUNT_W'(1);
        else if (digit_count_reg > COUNT_W'(MAX_DIGITS))
            count_lim = COUNT_W'(MAX_DIGITS);
        else
            count_lim = digit_count_reg;
    end

    assign last_idx_calc = IDX_W'(count_lim - COUNT_W'(1));

    // shared multiplier: weight steps, then radix_0 * weight_0 in two halves
    assign weight_rd = weight_reg[idx_reg];
    assign mul_a     = radix_reg[2'(idx_reg)];
    assign mul_b     = (state_reg == S_PHI)
                       ? INDEX_W'(weight_rd[WEIGHT_W-1:INDEX_W])
                       : weight_rd[INDEX_W-1:0];
    assign mul_out   = MUL_W'(mul_a) * MUL_W'(mul_b);

    assign div_req.start    = div_start_reg;
    assign div_req.dividend = rem_reg;
    assign div_req.divisor  = weight_rd;

    lmrd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        last_idx_next  = last_idx_reg;
        rem_next       = rem_reg;
        plo_next       = plo_reg;
        oor_next       = oor_reg;
        div_start_next = 1'b0;
        valid_next     = 1'b0;
        position_next  = position_reg;
        digit_next     = digit_reg;
        last_next      = last_reg;
        weight_we      = 1'b0;
        weight_waddr   = idx_reg;
        weight_wdata   = mul_out;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    rem_next      = joint_index;
                    last_idx_next = last_idx_calc;
                    idx_next      = last_idx_calc;
                    weight_we     = 1'b1;
                    weight_waddr  = last_idx_calc;
                    weight_wdata  = WEIGHT_W'(1);
                    state_next    = (last_idx_calc == '0) ? S_PLO : S_WGT;
                end
            end
            S_WGT:
            begin
                weight_we    = 1'b1;
                weight_waddr = idx_reg - IDX_W'(1);
                weight_wdata = mul_out;
                idx_next     = idx_reg - IDX_W'(1);
                if (idx_reg == IDX_W'(1))
                    state_next = S_PLO;
            end
            S_PLO:
            begin
                plo_next   = mul_out;
                state_next = S_PHI;
            end
            S_PHI:
            begin
                // product >= 2^32 means no 32-bit index can reach it
                oor_next = (mul_out == '0) && (plo_reg[MUL_W-1:INDEX_W] == '0)
                           && (rem_reg >= plo_reg[INDEX_W-1:0]);
                div_start_next = 1'b1;
                state_next     = S_DIV;
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    valid_next    = 1'b1;
                    position_next = POS_W'(idx_reg);
                    digit_next    = div_rsp.quotient;
                    last_next     = (idx_reg == last_idx_reg);
                    rem_next      = div_rsp.remainder;
                    if (idx_reg == last_idx_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next       = idx_reg + IDX_W'(1);
                        div_start_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            last_idx_reg  <= '0;
            div_start_reg <= 1'b0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            last_idx_reg  <= last_idx_next;
            div_start_reg <= div_start_next;
            valid_reg     <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        plo_reg      <= plo_next;
        oor_reg      <= oor_next;
        position_reg <= position_next;
        digit_reg    <= digit_next;
        last_reg     <= last_next;
        if (weight_we)
            weight_reg[weight_waddr] <= weight_wdata;
    end

    assign busy         = (state_reg != S_IDLE);
    assign valid        = valid_reg;
    assign position     = position_reg;
    assign digit        = digit_reg;
    assign last         = last_reg;
    assign out_of_range = oor_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/lmrd_div.sv =====
// ----------------------------------------------------------------------------
// lmrd_div
// Restoring divider, 32-bit dividend by 48-bit divisor, one quotient bit
// per cycle. A zero divisor gives an all-ones quotient and the dividend back.
// ----------------------------------------------------------------------------
`default_nettype none

module lmrd_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lmrd_pkg::div_req_t req,
    output lmrd_pkg::div_rsp_t     rsp
);
    import lmrd_pkg::*;

    localparam int STEP_W = $clog2(INDEX_W);

    logic               run_reg, run_next;
    logic               done_reg, done_next;
    logic [STEP_W-1:0]  cnt_reg, cnt_next;
    logic [INDEX_W-1:0] q_reg, q_next;
    logic [INDEX_W-1:0] r_reg, r_next;
    logic [INDEX_W-1:0] d_reg, d_next;
    logic               big_reg, big_next;

    logic [INDEX_W-1:0] trial;
    logic               take;

    assign trial = {r_reg[INDEX_W-2:0], q_reg[INDEX_W-1]};
    assign take  = !big_reg && (trial >= d_reg);

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        big_next  = big_reg;
        if (req.start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            q_next   = req.dividend;
            r_next   = '0;
            d_next   = req.divisor[INDEX_W-1:0];
            big_next = |req.divisor[WEIGHT_W-1:INDEX_W];
        end
        else if (run_reg)
        begin
            r_next   = take ? (trial - d_reg) : trial;
            q_next   = {q_reg[INDEX_W-2:0], take};
            cnt_next = cnt_reg + STEP_W'(1);
            if (cnt_reg == STEP_W'(INDEX_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        big_reg <= big_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = q_reg;
    assign rsp.remainder = r_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/lmrd_checker.sv =====
// ----------------------------------------------------------------------------
// lmrd_checker
// Port-level sequencing checks for the mixed-radix digit splitter.
// ----------------------------------------------------------------------------
`default_nettype none

`include "linear_to_mixed_radix_digits_top_defines.svh"

module lmrd_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic valid,
    input wire logic last
);

    `LMRD_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `LMRD_ASSERT_NOW(a_mid_digit_busy, valid && !last, busy)
    `LMRD_ASSERT_NOW(a_last_frees, valid && last, !busy)
    `LMRD_ASSERT_NEXT(a_digit_spacing, valid, !valid)

endmodule

bind linear_to_mixed_radix_digits_top lmrd_checker u_lmrd_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .valid (valid),
    .last  (last)
);

`default_nettype wire

// ===== tb/tb_linear_to_mixed_radix_digits_top.sv =====
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// Testbench for linear_to_mixed_radix_digits_top
// Drives linear indexes through the command port under several radix
// settings, predicts every digit item in a local model of the splitter and
// compares each strobed result field by field, in order.
// ----------------------------------------------------------------------------

module tb_linear_to_mixed_radix_digits_top;
    import lmrd_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 160;
    localparam int ITEMS_PER_PHASE = 62;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_5 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [POS_W-1:0]   position;
        logic [INDEX_W-1:0] digit;
        logic               last;
        logic               oor;
    } digit_rec_t;

    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] data;
        logic [INDEX_W-1:0]    joint;
        bit                    typed;
        logic [INDEX_W-1:0]    exp_digit;
        bit                    exp_oor;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [INDEX_W-1:0]    joint_index;
    logic                  valid;
    logic [POS_W-1:0]      position;
    logic [INDEX_W-1:0]    digit;
    logic                  last;
    logic                  out_of_range;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic [COUNT_W-1:0]    mdl_count;
    logic [RADIX_W-1:0]    mdl_radix  [NUM_RADIX];
    logic [WEIGHT_W-1:0]   mdl_weight [NUM_RADIX];

    digit_rec_t pending_digits[$];
    dir_row_t   dir_table[$];
    int         mismatches = 0;
    int         cycles = 0;

    linear_to_mixed_radix_digits_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .joint_index  (joint_index),
        .valid        (valid),
        .position     (position),
        .digit        (digit),
        .last         (last),
        .out_of_range (out_of_range),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic void queue_digit(input digit_rec_t r);
        pending_digits.insert(pending_digits.size(), r);
    endfunction

    function automatic void add_row(input dir_row_t r);
        dir_table.insert(dir_table.size(), r);
    endfunction

    function automatic int digits_used();
        int n;
        n = mdl_count;
        if (n == 0)
            n = 1;
        if (n > MAX_DIGITS_DEF)
            n = MAX_DIGITS_DEF;
        return n;
    endfunction

    function automatic void recompute_weights();
        logic [63:0] prod;
        int          i;
        for (i = 0; i < NUM_RADIX; i++)
            mdl_weight[i] = 1;
        for (i = digits_used() - 1; i > 0; i--) begin
            prod = mdl_radix[i] * mdl_weight[i];
            mdl_weight[i-1] = prod[WEIGHT_W-1:0];
        end
    endfunction

    function automatic void model_write(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_DIGIT_COUNT: mdl_count = data[COUNT_W-1:0];
            REG_RADIX_0, REG_RADIX_1, REG_RADIX_2, REG_RADIX_3:
                mdl_radix[idx - REG_RADIX_0] = data;
            default: return;
        endcase
        recompute_weights();
    endfunction

    function automatic void push_expected_digits(input logic [INDEX_W-1:0] idx);
        int          n;
        int          i;
        logic [63:0] rem;
        logic [63:0] product;
        logic [63:0] w;
        logic [63:0] quot;
        logic        oor;
        digit_rec_t  r;
        n = digits_used();
        rem = {32'b0, idx};
        product = mdl_radix[0] * mdl_weight[0];
        oor = (rem >= product);
        for (i = 0; i < n; i++) begin
            w = mdl_weight[i];
            r.position = i[POS_W-1:0];
            if (w == 0) begin
                r.digit = '1;
            end else begin
                quot = rem / w;
                r.digit = quot[INDEX_W-1:0];
                rem = rem % w;
            end
            r.last = (i == n - 1);
            r.oor = oor;
            queue_digit(r);
        end
    endfunction

    function automatic void report_mismatch(input string what, input digit_rec_t want,
                                            input digit_rec_t got);
        mismatches++;
        if (mismatches <= 10) begin
            $write("%0t %s: exp pos=%0d digit=%h last=%b oor=%b, ",
                   $realtime, what, want.position, want.digit, want.last, want.oor);
            $display("got pos=%0d digit=%h last=%b oor=%b",
                     got.position, got.digit, got.last, got.oor);
        end
    endfunction

    always @(posedge clk) begin : check_results
        digit_rec_t got;
        digit_rec_t want;
        if (rst_n && valid) begin
            got.position = position;
            got.digit = digit;
            got.last = last;
            got.oor = out_of_range;
            if (pending_digits.size() == 0) begin
                want = '0;
                report_mismatch("unexpected item", want, got);
            end else begin
                want = pending_digits.pop_front();
                if (got.position !== want.position || got.digit !== want.digit ||
                    got.last !== want.last || got.oor !== want.oor)
                    report_mismatch("item mismatch", want, got);
            end
        end
    end

    function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
        dir_row_t r;
        r = '{default: 0};
        r.is_cfg = 1;
        r.reg_idx = idx;
        r.data = data;
        return r;
    endfunction

    function automatic dir_row_t item_row(input logic [INDEX_W-1:0] joint);
        dir_row_t r;
        r = '{default: 0};
        r.joint = joint;
        return r;
    endfunction

    // single-digit setting only: position 0, last set
    function automatic dir_row_t typed_row(input logic [INDEX_W-1:0] joint,
                                           input logic [INDEX_W-1:0] d, input bit o);
        dir_row_t r;
        r = item_row(joint);
        r.typed = 1;
        r.exp_digit = d;
        r.exp_oor = o;
        return r;
    endfunction

    task automatic send_index(input logic [INDEX_W-1:0] idx, input bit typed,
                              input logic [INDEX_W-1:0] d, input bit o);
        digit_rec_t r;
        start <= 1'b1;
        joint_index <= idx;
        do @(posedge clk); while (busy);
        if (typed) begin
            r.position = '0;
            r.digit = d;
            r.last = 1'b1;
            r.oor = o;
            queue_digit(r);
        end else begin
            push_expected_digits(idx);
        end
    endtask

    task automatic sender_gap(input int pct);
        int len;
        if ($urandom_range(99) < pct) begin
            len = ($urandom_range(3) == 0) ? $urandom_range(150, 1) : $urandom_range(8, 1);
            start <= 1'b0;
            repeat (len) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (pending_digits.size() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        model_write(idx, data);
    endtask

    task automatic end_writes();
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_setting(input logic [CFG_DATA_W-1:0] cnt,
                                 input logic [CFG_DATA_W-1:0] r0, input logic [CFG_DATA_W-1:0] r1,
                                 input logic [CFG_DATA_W-1:0] r2, input logic [CFG_DATA_W-1:0] r3);
        write_reg(REG_DIGIT_COUNT, cnt);
        write_reg(REG_RADIX_0, r0);
        write_reg(REG_RADIX_1, r1);
        write_reg(REG_RADIX_2, r2);
        write_reg(REG_RADIX_3, r3);
        end_writes();
    endtask

    task automatic random_setting();
        logic [CFG_DATA_W-1:0] cnt;
        logic [CFG_DATA_W-1:0] rad [NUM_RADIX];
        int                    i;
        cnt = CFG_DATA_W'($urandom);
        cnt[COUNT_W-1:0] = ($urandom_range(4) == 0) ? COUNT_W'($urandom_range(7))
                                                     : COUNT_W'($urandom_range(4, 1));
        for (i = 0; i < NUM_RADIX; i++) begin
            case ($urandom_range(19))
                0:             rad[i] = 16'd0;
                1, 2:          rad[i] = 16'hFFFF;
                3, 4:          rad[i] = 16'd1;
                5, 6, 7, 8, 9: rad[i] = 16'($urandom_range(16, 2));
                default:       rad[i] = 16'($urandom);
            endcase
        end
        if ($urandom_range(4) == 0) begin
            case ($urandom_range(2))
                0:       write_reg(REG_SPARE_5, CFG_DATA_W'($urandom));
                1:       write_reg(REG_SPARE_6, CFG_DATA_W'($urandom));
                default: write_reg(REG_SPARE_7, CFG_DATA_W'($urandom));
            endcase
        end
        apply_setting(cnt, rad[0], rad[1], rad[2], rad[3]);
    endtask

    function automatic logic [INDEX_W-1:0] pick_index();
        logic [63:0] product;
        logic [63:0] r;
        product = mdl_radix[0] * mdl_weight[0];
        r = {$urandom, $urandom};
        case ($urandom_range(9))
            0, 1, 2, 3: if (product != 0) return INDEX_W'(r % product);
            4: if (product != 0 && product <= 64'h1_0000_0000) return INDEX_W'(product - 1);
            5: if (product < 64'h1_0000_0000) return product[INDEX_W-1:0];
            6: return INDEX_W'($urandom_range(255));
            7: return 32'hFFFF_FFFF - INDEX_W'($urandom_range(15));
            default: ;
        endcase
        return $urandom;
    endfunction

    initial begin : stimulus
        int       i;
        int       k;
        int       phase;
        int       pct;
        int       left;
        int       burst;
        bit       writing;
        dir_row_t row;

        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        joint_index = '0;
        cfg_we = 1'b0;
        cfg_index = REG_DIGIT_COUNT;
        cfg_data = '0;

        mdl_count = 1;
        for (i = 0; i < NUM_RADIX; i++)
            mdl_radix[i] = 1;
        recompute_weights();

        // reset state: one digit, product 1
        add_row(typed_row(32'h0000_0000, 32'h0000_0000, 1'b0));
        add_row(typed_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
        add_row(typed_row(32'h0000_0001, 32'h0000_0001, 1'b1));
        // zero radix: product zero flags everything
        add_row(cfg_row(REG_RADIX_0, 16'h0000));
        add_row(typed_row(32'h0000_0005, 32'h0000_0005, 1'b1));
        add_row(typed_row(32'h0000_0000, 32'h0000_0000, 1'b1));
        add_row(cfg_row(REG_RADIX_0, 16'hFFFF));
        add_row(typed_row(32'h0000_FFFE, 32'h0000_FFFE, 1'b0));
        add_row(typed_row(32'h0000_FFFF, 32'h0000_FFFF, 1'b1));
        // count zero acts as one
        add_row(cfg_row(REG_DIGIT_COUNT, 16'h0000));
        add_row(typed_row(32'h0000_0007, 32'h0000_0007, 1'b0));
        // upper data bits of the count are dropped
        add_row(cfg_row(REG_DIGIT_COUNT, 16'hFFF9));
        add_row(typed_row(32'h0001_0000, 32'h0001_0000, 1'b1));
        // widest setting
        add_row(cfg_row(REG_DIGIT_COUNT, 16'd4));
        add_row(cfg_row(REG_RADIX_1, 16'hFFFF));
        add_row(cfg_row(REG_RADIX_2, 16'hFFFF));
        add_row(cfg_row(REG_RADIX_3, 16'hFFFF));
        add_row(item_row(32'h0000_0000));
        add_row(item_row(32'hFFFF_FFFF));
        add_row(item_row(32'h1234_5678));
        // count saturates
        add_row(cfg_row(REG_DIGIT_COUNT, 16'd7));
        add_row(item_row(32'h89AB_CDEF));
        // zero weight inside the chain
        add_row(cfg_row(REG_RADIX_2, 16'h0000));
        add_row(item_row(32'hABCD_EF01));
        add_row(item_row(32'h0000_0000));
        // writes to unused indexes change nothing
        add_row(cfg_row(REG_SPARE_5, 16'h1234));
        add_row(cfg_row(REG_SPARE_7, 16'hFFFF));
        add_row(item_row(32'h0000_FFFF));
        add_row(cfg_row(REG_DIGIT_COUNT, 16'd2));
        add_row(cfg_row(REG_RADIX_0, 16'd2));
        add_row(cfg_row(REG_RADIX_1, 16'd3));
        add_row(cfg_row(REG_RADIX_2, 16'd1));
        add_row(cfg_row(REG_RADIX_3, 16'd1));
        add_row(item_row(32'd5));
        add_row(item_row(32'd6));
        add_row(cfg_row(REG_DIGIT_COUNT, 16'd3));
        add_row(cfg_row(REG_RADIX_2, 16'd4));
        add_row(item_row(32'd23));
        add_row(item_row(32'd24));
        add_row(cfg_row(REG_DIGIT_COUNT, 16'd5));
        add_row(item_row(32'h0FFF_FFFF));
        // every radix zero
        add_row(cfg_row(REG_RADIX_0, 16'h0000));
        add_row(cfg_row(REG_RADIX_1, 16'h0000));
        add_row(cfg_row(REG_RADIX_2, 16'h0000));
        add_row(cfg_row(REG_RADIX_3, 16'h0000));
        add_row(cfg_row(REG_DIGIT_COUNT, 16'd4));
        add_row(item_row(32'hDEAD_BEEF));
        add_row(cfg_row(REG_DIGIT_COUNT, 16'd6));
        add_row(cfg_row(REG_RADIX_0, 16'd1));
        add_row(cfg_row(REG_RADIX_1, 16'd1));
        add_row(cfg_row(REG_RADIX_2, 16'd1));
        add_row(cfg_row(REG_RADIX_3, 16'd1));
        add_row(item_row(32'd3));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        writing = 0;
        foreach (dir_table[i]) begin
            row = dir_table[i];
            if (row.is_cfg) begin
                if (!writing)
                    wait_idle();
                write_reg(row.reg_idx, row.data);
                writing = 1;
            end else begin
                if (writing)
                    end_writes();
                writing = 0;
                send_index(row.joint, row.typed, row.exp_digit, row.exp_oor);
            end
        end

        for (phase = 0; phase < 3; phase++) begin
            pct = (phase == 0) ? 12 : (phase == 1) ? 70 : 0;
            wait_idle();
            if (phase == 0)
                apply_setting(16'd4, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            else if (phase == 1)
                apply_setting(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
            else
                random_setting();
            left = ITEMS_PER_PHASE;
            while (left > 0) begin
                burst = $urandom_range(20, 6);
                for (k = 0; k < burst && left > 0; k++) begin
                    send_index(pick_index(), 1'b0, '0, 1'b0);
                    left--;
                    sender_gap(pct);
                end
                if (left > 0) begin
                    wait_idle();
                    random_setting();
                end
            end
        end

        wait_idle();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0 && pending_digits.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
